>>> rtl/swtt_pkg.sv
// Shared types and constants for the software timer table.
// Used by swtt_mem, swtt_ctrl and software_timer_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swtt_pkg;

  localparam int ID_W            = 16;
  localparam int CNT_W           = 16;
  localparam int WORD_W          = ID_W + CNT_W;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_RESTART = 2'd2,
    OP_FREE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              expired_valid;
    logic [ID_W-1:0]   expired_id;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/swtt_mem.sv
// Slot memory: one word per slot holding the timer ID and its tick count.
// Synchronous write, registered read; uses swtt_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module swtt_mem
  import swtt_pkg::*;
#(
  parameter int DEPTH = TIMER_SLOTS_DEF,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/swtt_ctrl.sv
// Scan sequencer: walks the slot memory once per request, one slot a cycle
// except on stalls; makes the results. Uses swtt_pkg types; drives swtt_mem.
`timescale 1ns / 1ps
`default_nettype none

module swtt_ctrl
  import swtt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  parameter int AW          = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire op_t               in_op,
  input  wire logic [ID_W-1:0]   in_id,
  input  wire logic [CNT_W-1:0]  in_cnt,
  input  wire logic              out_free,
  output logic                   push,
  output res_t                   res,
  output logic                   we,
  output logic      [AW-1:0]     waddr,
  output logic      [WORD_W-1:0] wdata,
  output logic                   re,
  output logic      [AW-1:0]     raddr,
  input  wire logic [WORD_W-1:0] rdata
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state;
  logic [AW-1:0]        addr;
  op_t                  op;
  logic [ID_W-1:0]      id;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic                 have_free;
  logic [AW-1:0]        free_slot;
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_id;
  logic [RES_CNT_W-1:0] n;

  logic [ID_W-1:0]  slot_id;
  logic [CNT_W-1:0] slot_cnt;
  logic [CNT_W-1:0] dec_cnt;
  logic             expire;
  logic             stall;
  logic             last_slot;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    slot_id   = rdata[WORD_W-1:CNT_W];
    slot_cnt  = rdata[CNT_W-1:0];
    dec_cnt   = (slot_cnt != '0) ? slot_cnt - CNT_W'(1) : slot_cnt;
    expire    = (op == OP_TICK) && (slot_id != '0) && (dec_cnt == '0) &&
                (n < RES_CNT_W'(MAX_RESULTS));
    // A second expiry must push the held one out first.
    stall     = expire && pend_valid && !out_free;
    last_slot = (addr == AW'(TIMER_SLOTS - 1));
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    re    = 1'b0;
    raddr = addr + AW'(1);
    push  = 1'b0;
    res   = '{status: ST_DONE, expired_valid: 1'b0, expired_id: '0, last: 1'b1};
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        re    = in_valid;
        raddr = '0;
      end
      S_SCAN: begin
        if (!stall) begin
          re = !last_slot;
          case (op)
            OP_TICK: begin
              if (slot_id != '0) begin
                we    = 1'b1;
                wdata = expire ? {{ID_W{1'b0}}, dec_cnt} : {slot_id, dec_cnt};
              end
              if (expire && pend_valid) begin
                push = 1'b1;
                res  = '{status: ST_DONE, expired_valid: 1'b1,
                         expired_id: pend_id, last: 1'b0};
              end
            end
            OP_SET: begin
              if (!done && slot_id == '0) begin
                we    = 1'b1;
                wdata = {id, cnt};
              end
            end
            OP_RESTART: begin
              if (!done && slot_id == id) begin
                we    = 1'b1;
                wdata = {slot_id, cnt};
              end
            end
            OP_FREE: begin
              if (slot_id == id) begin
                we    = 1'b1;
                wdata = {{ID_W{1'b0}}, slot_cnt};
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          case (op)
            OP_TICK: begin
              if (pend_valid) begin
                res = '{status: ST_DONE, expired_valid: 1'b1,
                        expired_id: pend_id, last: 1'b1};
              end
            end
            OP_SET: begin
              res.status = done ? ST_DONE : ST_NO_FREE;
            end
            OP_RESTART: begin
              res.status = (done || have_free) ? ST_DONE : ST_NO_FREE;
              // No match: the highest free slot seen takes the timer.
              if (!done && have_free) begin
                we    = 1'b1;
                waddr = free_slot;
                wdata = {id, cnt};
              end
            end
            OP_FREE: begin
              res.status = done ? ST_DONE : ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      done       <= 1'b0;
      have_free  <= 1'b0;
      pend_valid <= 1'b0;
      n          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (last_slot) begin
            state <= S_IDLE;
            addr  <= '0;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op         <= in_op;
            id         <= in_id;
            cnt        <= in_cnt;
            addr       <= '0;
            done       <= 1'b0;
            have_free  <= 1'b0;
            pend_valid <= 1'b0;
            n          <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            case (op)
              OP_TICK: begin
                if (expire) begin
                  pend_valid <= 1'b1;
                  pend_id    <= slot_id;
                  n          <= n + RES_CNT_W'(1);
                end
              end
              OP_SET: begin
                if (slot_id == '0) begin
                  done <= 1'b1;
                end
              end
              OP_RESTART: begin
                if (!done) begin
                  if (slot_id == '0) begin
                    have_free <= 1'b1;
                    free_slot <= addr;
                  end
                  if (slot_id == id) begin
                    done <= 1'b1;
                  end
                end
              end
              OP_FREE: begin
                if (slot_id == id) begin
                  done <= 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (last_slot) begin
              state <= S_DONE;
            end else begin
              addr <= addr + AW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/software_timer_table.sv
// Top level of the software timer table: stream ports, output register,
// and the scan sequencer with its slot memory. Uses swtt_pkg, swtt_ctrl, swtt_mem.
//
//   Port group | Dir | Carries
//   s_*        | in  | request: tuser = operation, tdata = id, tick_count
//   m_*        | out | result: tdata = status, expired_id; tuser, tlast
//
// Every request scans all slots, one per cycle, a pace set by the single read
// port of the slot memory. A tick pauses its scan for as long as an expiry
// meets a full output register, and every request holds its last cycle until
// that register is free.
// After reset the memory is swept clear; s_tready is low then.
// A new request is taken while the last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table
  import swtt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] id, [31:16] tick_count
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [1:0] status, [17:2] expired_id, rest zero
  output logic             m_tuser,   // [0] expired_valid
  output logic             m_tlast
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic              out_free;
  logic              push;
  res_t              res;
  res_t              out_res;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  assign out_free = !m_tvalid || m_tready;

  swtt_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .AW          (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (op_t'(s_tuser)),
    .in_id    (s_tdata[15:0]),
    .in_cnt   (s_tdata[31:16]),
    .out_free (out_free),
    .push     (push),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  swtt_mem #(
    .DEPTH (TIMER_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.expired_id, out_res.status};
  assign m_tuser = out_res.expired_valid;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire
